@@ sv/eps_pkg.sv @@
`default_nettype none
package eps_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_BIND    = 3'd0;
  localparam logic [2:0] CFG_UNBIND  = 3'd1;
  localparam logic [2:0] CFG_HOP     = 3'd2;
  localparam logic [2:0] CFG_RECOVER = 3'd3;
  localparam logic [2:0] CFG_REBIND  = 3'd4;

  // Event actions
  localparam logic [1:0] ACT_BIND    = 2'd0;
  localparam logic [1:0] ACT_UNBIND  = 2'd1;
  localparam logic [1:0] ACT_STEP    = 2'd2;
  localparam logic [1:0] ACT_RECOVER = 2'd3;

  // Input op codes
  localparam logic OP_INIT  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // Value kinds written by a rewrite
  localparam logic [2:0] VK_ZERO      = 3'd0;
  localparam logic [2:0] VK_UNBIND    = 3'd1;
  localparam logic [2:0] VK_REBIND    = 3'd2;
  localparam logic [2:0] VK_RECOVER   = 3'd3;
  localparam logic [2:0] VK_BIND      = 3'd4;
  localparam logic [2:0] VK_HOP_FREE  = 3'd5;
  localparam logic [2:0] VK_HOP_BOUND = 3'd6;

  localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;
  localparam logic [31:0] WAIT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // One table rewrite: entry quarter*SITES + site + wr_off gets a value of
  // the given kind; the hop kinds look at entry SITES + site + rd_off first.
  typedef struct packed {
    logic [2:0]        quarter;
    logic signed [2:0] wr_off;
    logic [2:0]        kind;
    logic signed [2:0] rd_off;
  } rw_op_t;

  function automatic rw_op_t mk_op(input logic [2:0] q, input logic signed [2:0] wo,
                                   input logic [2:0] k, input logic signed [2:0] ro);
    rw_op_t o;
    o.quarter = q;
    o.wr_off  = wo;
    o.kind    = k;
    o.rd_off  = ro;
    return o;
  endfunction

  function automatic logic [3:0] act_len(input logic [1:0] a);
    logic [3:0] n;
    case (a)
      ACT_BIND:   n = 4'd5;
      ACT_UNBIND: n = 4'd5;
      ACT_STEP:   n = 4'd9;
      default:    n = 4'd2;
    endcase
    return n;
  endfunction

  function automatic rw_op_t act_op(input logic [1:0] a, input logic [3:0] k);
    rw_op_t o;
    o = mk_op(3'd0, 3'sd0, VK_ZERO, 3'sd0);
    case (a)
      ACT_BIND: begin
        case (k)
          4'd0:    o = mk_op(3'd0,  3'sd0, VK_ZERO,     3'sd0);
          4'd1:    o = mk_op(3'd1,  3'sd0, VK_UNBIND,   3'sd0);
          4'd2:    o = mk_op(3'd2, -3'sd1, VK_ZERO,     3'sd0);
          4'd3:    o = mk_op(3'd2,  3'sd0, VK_HOP_FREE, 3'sd1);
          default: o = mk_op(3'd3,  3'sd0, VK_ZERO,     3'sd0);
        endcase
      end
      ACT_UNBIND: begin
        case (k)
          4'd0:    o = mk_op(3'd0,  3'sd0, VK_REBIND,    3'sd0);
          4'd1:    o = mk_op(3'd1,  3'sd0, VK_ZERO,      3'sd0);
          4'd2:    o = mk_op(3'd2,  3'sd0, VK_ZERO,      3'sd0);
          4'd3:    o = mk_op(3'd2, -3'sd1, VK_HOP_BOUND, -3'sd1);
          default: o = mk_op(3'd3,  3'sd0, VK_RECOVER,   3'sd0);
        endcase
      end
      ACT_STEP: begin
        case (k)
          4'd0:    o = mk_op(3'd0,  3'sd0, VK_REBIND,    3'sd0);
          4'd1:    o = mk_op(3'd0,  3'sd1, VK_ZERO,      3'sd0);
          4'd2:    o = mk_op(3'd1,  3'sd0, VK_ZERO,      3'sd0);
          4'd3:    o = mk_op(3'd1,  3'sd1, VK_UNBIND,    3'sd0);
          4'd4:    o = mk_op(3'd2, -3'sd1, VK_HOP_BOUND, -3'sd1);
          4'd5:    o = mk_op(3'd2,  3'sd0, VK_ZERO,      3'sd0);
          4'd6:    o = mk_op(3'd2,  3'sd1, VK_HOP_FREE,  3'sd2);
          4'd7:    o = mk_op(3'd3,  3'sd0, VK_RECOVER,   3'sd0);
          default: o = mk_op(3'd3,  3'sd1, VK_ZERO,      3'sd0);
        endcase
      end
      default: begin
        case (k)
          4'd0:    o = mk_op(3'd0, 3'sd0, VK_BIND, 3'sd0);
          default: o = mk_op(3'd3, 3'sd0, VK_ZERO, 3'sd0);
        endcase
      end
    endcase
    return o;
  endfunction

  // Boundary overrides, addressed from site zero
  function automatic rw_op_t bound_op(input logic [2:0] k);
    rw_op_t o;
    case (k)
      3'd0:    o = mk_op(3'd0,  3'sd0, VK_ZERO,   3'sd0);
      3'd1:    o = mk_op(3'd1,  3'sd0, VK_ZERO,   3'sd0);
      3'd2:    o = mk_op(3'd2,  3'sd0, VK_ZERO,   3'sd0);
      3'd3:    o = mk_op(3'd3,  3'sd0, VK_ZERO,   3'sd0);
      3'd4:    o = mk_op(3'd1, -3'sd1, VK_ZERO,   3'sd0);
      3'd5:    o = mk_op(3'd2, -3'sd1, VK_UNBIND, 3'sd0);
      3'd6:    o = mk_op(3'd3, -3'sd1, VK_ZERO,   3'sd0);
      default: o = mk_op(3'd4, -3'sd1, VK_ZERO,   3'sd0);
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

@@ sv/eps_in_if.sv @@
`default_nettype none
interface eps_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] draw_wait;
  logic [31:0] draw_pick;

  modport source (output valid, output op, output draw_wait, output draw_pick, input ready);
  modport sink   (input valid, input op, input draw_wait, input draw_pick, output ready);
endinterface
`default_nettype wire

@@ sv/eps_out_if.sv @@
`default_nettype none
interface eps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  site;
  logic [31:0] wait_time;
  logic [47:0] elapsed_time;

  modport source (output valid, output action, output site, output wait_time,
                  output elapsed_time, input ready);
  modport sink   (input valid, input action, input site, input wait_time,
                  input elapsed_time, output ready);
endinterface
`default_nettype wire

@@ sv/eps_ram.sv @@
`default_nettype none
module eps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/eps_wait.sv @@
`default_nettype none
module eps_wait
  import eps_pkg::*;
#(
  parameter int SUM_W = 42
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      draw,
  input  wire logic [SUM_W-1:0] sum,
  output logic                  done,
  output logic      [31:0]      wait_val
);
  localparam int LNW = 38;

  localparam logic [3:0] W_IDLE = 4'd0;
  localparam logic [3:0] W_NORM = 4'd1;
  localparam logic [3:0] W_SQM  = 4'd2;
  localparam logic [3:0] W_SQA  = 4'd3;
  localparam logic [3:0] W_LNH  = 4'd4;
  localparam logic [3:0] W_LNL  = 4'd5;
  localparam logic [3:0] W_LNS  = 4'd6;
  localparam logic [3:0] W_DIV  = 4'd7;
  localparam logic [3:0] W_END  = 4'd8;

  logic [3:0]       state;
  logic [31:0]      x;
  logic [4:0]       e;
  logic [31:0]      f;
  logic [63:0]      sq;
  logic [5:0]       k;
  logic [53:0]      pa;
  logic [47:0]      pb;
  logic [LNW-1:0]   dv;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] dsr;

  logic [32:0]      t;
  logic [LNW-1:0]   nl;
  logic [SUM_W:0]   r2;
  logic [SUM_W:0]   r2_sub;

  assign t      = sq[63:31];
  assign nl     = {6'd32 - {1'b0, e}, 32'd0} - {6'd0, f};
  assign r2     = {rem, dv[LNW-1]};
  assign r2_sub = r2 - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            dsr <= sum;
            if (sum == '0) begin
              wait_val <= WAIT_MAX;
              state    <= W_END;
            end else begin
              x     <= (draw == 32'd0) ? 32'd1 : draw;
              e     <= 5'd31;
              state <= W_NORM;
            end
          end
        end
        W_NORM: begin
          // one bit a cycle until the leading one sits at bit 31
          if (x[31]) begin
            k     <= '0;
            f     <= '0;
            state <= W_SQM;
          end else begin
            x <= {x[30:0], 1'b0};
            e <= e - 5'd1;
          end
        end
        W_SQM: begin
          sq    <= {32'd0, x} * {32'd0, x};
          state <= W_SQA;
        end
        W_SQA: begin
          f <= {f[30:0], t[32]};
          x <= t[32] ? t[32:1] : t[31:0];
          k <= k + 6'd1;
          state <= (k == 6'd31) ? W_LNH : W_SQM;
        end
        W_LNH: begin
          pa    <= 54'(nl[LNW-1:16]) * 54'(LN2_Q32);
          state <= W_LNL;
        end
        W_LNL: begin
          pb    <= 48'(nl[15:0]) * 48'(LN2_Q32);
          state <= W_LNS;
        end
        W_LNS: begin
          dv    <= LNW'((pa + 54'(pb[47:16])) >> 16);
          rem   <= '0;
          k     <= '0;
          state <= W_DIV;
        end
        W_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!r2_sub[SUM_W]) begin
            rem <= r2_sub[SUM_W-1:0];
            dv  <= {dv[LNW-2:0], 1'b1};
          end else begin
            rem <= r2[SUM_W-1:0];
            dv  <= {dv[LNW-2:0], 1'b0};
          end
          k <= k + 6'd1;
          if (k == 6'(LNW - 1)) begin
            state <= W_END;
          end
        end
        W_END: begin
          if (dsr != '0) begin
            wait_val <= (dv[LNW-1:32] != '0) ? WAIT_MAX : dv[31:0];
          end
          done  <= 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/exclusion_process_event_step_core.sv @@
`default_nettype none
// Event engine for an exclusion lattice of SITES sites (binding, unbinding,
// forward stepping, recovery). The 4*SITES rate table lives in one RAM with
// a registered read. An init request fills the table (binding quarter
// gets bind_rate, the rest zero) and clears the time. An event request
// sums the table, forms the pick threshold, runs the running-sum pick,
// then does the rate rewrites and boundary overrides (one entry a cycle,
// with an extra read state for entries that need a neighbor read), and
// ends in the wait unit (leading-one search, 32 squarings, each a multiply
// state and a shift state, ln2 scaling, 38-step division). The table RAM
// port is the limit for the scans. One request is in flight at a time;
// the next request is taken while a result still waits in the output
// register. The table holds no defined contents until the first init
// request; the user must write configuration only while the block is idle,
// which the block itself does not enforce.
module exclusion_process_event_step_core
  import eps_pkg::*;
#(
  parameter int SITES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  eps_in_if.sink      req,
  eps_out_if.source   rsp
);
  localparam int DEPTH = 4 * SITES;
  localparam int AW    = $clog2(DEPTH);
  localparam int ADDRW = AW + 2;
  localparam int SW    = $clog2(SITES);
  localparam int SUMW  = 32 + AW;
  localparam int PW    = SUMW + 32;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INIT    = 4'd1;
  localparam logic [3:0] ST_SUM     = 4'd2;
  localparam logic [3:0] ST_SUM_END = 4'd3;
  localparam logic [3:0] ST_MUL     = 4'd4;
  localparam logic [3:0] ST_PICK    = 4'd5;
  localparam logic [3:0] ST_UPD     = 4'd6;
  localparam logic [3:0] ST_UPD_RD  = 4'd7;
  localparam logic [3:0] ST_WAIT    = 4'd8;
  localparam logic [3:0] ST_FIN     = 4'd9;

  // configuration
  logic [31:0] bind_rate, unbind_rate, hop_rate, recover_rate;
  logic [23:0] rebind_factor;
  logic [31:0] rebind_val;
  logic [55:0] rebind_prod;

  // sequencer
  logic [3:0]      state;
  logic [AW-1:0]   cnt;
  logic            rv;
  logic            issue_done;
  logic            is_init;
  logic [31:0]     dw;
  logic [31:0]     dp;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] cum;
  logic [SUMW-1:0] thr;
  logic [PW-1:0]   prod;
  logic [4:0]      bit_cnt;
  logic [1:0]      dq;
  logic [SW-1:0]   ds;
  logic [1:0]      act;
  logic [SW-1:0]   site;
  logic [4:0]      pc;
  logic [47:0]     time_now;
  logic            wt_start;
  logic            wt_done;
  logic [31:0]     wt_val;
  logic [31:0]     wait_r;

  // output register
  logic            out_valid;
  logic [1:0]      out_action;
  logic [5:0]      out_site;
  logic [31:0]     out_wait;
  logic [47:0]     out_elapsed;

  // table RAM
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  // rewrite decode
  logic [3:0]       cur_len;
  logic             in_bound;
  logic [4:0]       bk;
  rw_op_t           cur_op;
  logic             op_reads;
  logic             op_last;
  logic [ADDRW-1:0] wr_addr;
  logic [ADDRW-1:0] rd_addr;
  logic             wr_ok;
  logic [31:0]      wr_val;
  logic [SUMW-1:0]  cum_next;
  logic             hit;
  logic [48:0]      time_sum;
  logic [47:0]      time_next;
  logic [SW+5:0]    site_ext;

  eps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  eps_wait #(.SUM_W(SUMW)) u_wait (
    .clk      (clk),
    .rst      (rst),
    .start    (wt_start),
    .draw     (dw),
    .sum      (sum),
    .done     (wt_done),
    .wait_val (wt_val)
  );

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.action       = out_action;
  assign rsp.site         = out_site;
  assign rsp.wait_time    = out_wait;
  assign rsp.elapsed_time = out_elapsed;

  assign rebind_prod = 56'(rebind_factor) * 56'(bind_rate);

  // rewrite list: the action's own rewrites, then the eight boundary overrides
  assign cur_len  = act_len(act);
  assign in_bound = (pc >= {1'b0, cur_len});
  assign bk       = pc - {1'b0, cur_len};
  assign cur_op   = in_bound ? bound_op(bk[2:0]) : act_op(act, pc[3:0]);
  assign op_reads = (cur_op.kind == VK_HOP_FREE) || (cur_op.kind == VK_HOP_BOUND);
  assign op_last  = in_bound && (bk[2:0] == 3'd7);

  assign wr_addr = ADDRW'(cur_op.quarter) * ADDRW'(SITES)
                 + (in_bound ? '0 : ADDRW'(site))
                 + {{(ADDRW-3){cur_op.wr_off[2]}}, cur_op.wr_off};
  assign rd_addr = ADDRW'(SITES) + ADDRW'(site)
                 + {{(ADDRW-3){cur_op.rd_off[2]}}, cur_op.rd_off};
  // drop rewrites that land past the table
  assign wr_ok   = (wr_addr < ADDRW'(DEPTH));

  always_comb begin
    case (cur_op.kind)
      VK_UNBIND:    wr_val = unbind_rate;
      VK_REBIND:    wr_val = rebind_val;
      VK_RECOVER:   wr_val = recover_rate;
      VK_BIND:      wr_val = bind_rate;
      VK_HOP_FREE:  wr_val = (ram_rdata == unbind_rate) ? 32'd0 : hop_rate;
      VK_HOP_BOUND: wr_val = (ram_rdata == unbind_rate) ? hop_rate : 32'd0;
      default:      wr_val = 32'd0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = 32'd0;
    ram_raddr = cnt;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt < AW'(SITES)) ? bind_rate : 32'd0;
      end
      ST_UPD: begin
        ram_raddr = rd_addr[AW-1:0];
        ram_we    = !op_reads && wr_ok;
        ram_waddr = wr_addr[AW-1:0];
        ram_wdata = wr_val;
      end
      ST_UPD_RD: begin
        ram_we    = wr_ok;
        ram_waddr = wr_addr[AW-1:0];
        ram_wdata = wr_val;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign cum_next  = cum + SUMW'(ram_rdata);
  assign hit       = (cum_next >= thr);
  assign time_sum  = {1'b0, time_now} + 49'(wait_r);
  assign time_next = time_sum[48] ? TIME_MAX : time_sum[47:0];
  assign site_ext  = {6'd0, site};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bind_rate     <= 32'd65536;
      unbind_rate   <= 32'd65536;
      hop_rate      <= 32'd65536;
      recover_rate  <= 32'd65536;
      rebind_factor <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIND:    bind_rate     <= cfg_data;
        CFG_UNBIND:  unbind_rate   <= cfg_data;
        CFG_HOP:     hop_rate      <= cfg_data;
        CFG_RECOVER: recover_rate  <= cfg_data;
        CFG_REBIND:  rebind_factor <= cfg_data[23:0];
        default:     bind_rate     <= bind_rate;
      endcase
    end
  end

  // rebinding rate follows the registers; the user must hold them still while a request runs (not enforced here)
  always_ff @(posedge clk) begin
    rebind_val <= (rebind_prod[55:48] != 8'd0) ? WAIT_MAX : rebind_prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      time_now  <= '0;
      rv        <= 1'b0;
      wt_start  <= 1'b0;
    end else begin
      wt_start <= 1'b0;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            is_init <= (req.op == OP_INIT);
            dw      <= req.draw_wait;
            dp      <= req.draw_pick;
            cnt     <= '0;
            sum     <= '0;
            state   <= (req.op == OP_INIT) ? ST_INIT : ST_SUM;
          end
        end
        ST_INIT: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST) begin
            act    <= ACT_BIND;
            site   <= '0;
            wait_r <= 32'd0;
            state  <= ST_FIN;
          end
        end
        ST_SUM, ST_SUM_END: begin
          // issue one read a cycle, add the one that returns
          if (rv) begin
            sum <= sum + SUMW'(ram_rdata);
          end
          if (state == ST_SUM) begin
            rv  <= 1'b1;
            cnt <= cnt + AW'(1);
            if (cnt == LAST) begin
              state <= ST_SUM_END;
            end
          end else begin
            rv      <= 1'b0;
            prod    <= '0;
            bit_cnt <= '0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          // threshold = ceil(sum * draw_pick / 2^32), one draw bit a cycle
          prod    <= {prod[PW-2:0], 1'b0} + (dp[31] ? PW'(sum) : '0);
          dp      <= {dp[30:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (bit_cnt == 5'd0) begin
            // first cycle: settle the threshold, start the scan
            thr        <= SUMW'(prod[PW-1:32]) + SUMW'(|prod[31:0]);
            cum        <= '0;
            cnt        <= '0;
            dq         <= '0;
            ds         <= '0;
            issue_done <= 1'b0;
            rv         <= 1'b0;
            bit_cnt    <= 5'd1;
          end else begin
            rv <= !issue_done;
            if (!issue_done) begin
              cnt <= cnt + AW'(1);
              if (cnt == LAST) begin
                issue_done <= 1'b1;
              end
            end
            if (rv) begin
              cum <= cum_next;
              if (ds == SW'(SITES - 1)) begin
                ds <= '0;
                dq <= dq + 2'd1;
              end else begin
                ds <= ds + SW'(1);
              end
              if (hit) begin
                act   <= dq;
                site  <= ds;
                pc    <= '0;
                rv    <= 1'b0;
                state <= ST_UPD;
              end else if (dq == 2'd3 && ds == SW'(SITES - 1)) begin
                // no entry reached the threshold: fall back to entry zero
                act   <= ACT_BIND;
                site  <= '0;
                pc    <= '0;
                rv    <= 1'b0;
                state <= ST_UPD;
              end
            end
          end
        end
        ST_UPD, ST_UPD_RD: begin
          if (state == ST_UPD && op_reads) begin
            state <= ST_UPD_RD;
          end else begin
            pc <= pc + 5'd1;
            if (op_last) begin
              wt_start <= 1'b1;
              state    <= ST_WAIT;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_WAIT: begin
          if (wt_done) begin
            wait_r <= wt_val;
            state  <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the result until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_action  <= act;
            out_site    <= site_ext[5:0];
            out_wait    <= wait_r;
            out_elapsed <= is_init ? 48'd0 : time_next;
            time_now    <= is_init ? 48'd0 : time_next;
            bit_cnt     <= '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The table is never written while the block is idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("table write while idle");

  // The running sum of the pick never passes the table sum
  a_cum_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && bit_cnt != 5'd0) |-> (cum <= sum))
    else $error("pick running sum exceeds table sum");

  // The wait unit reports only while the sequencer waits for it
  a_wait_done: assert property (@(posedge clk) disable iff (rst)
    wt_done |-> (state == ST_WAIT))
    else $error("wait unit finished outside the wait phase");

  // A new request, taken only once the previous one has produced its result, starts the init fill or the table sum
  a_accept_after_fin: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_INIT || state == ST_SUM))
    else $error("accepted request did not start");

endmodule
`default_nettype wire

@@ tb/exclusion_process_event_step_core_tb.sv @@
`default_nettype none
module exclusion_process_event_step_core_tb;
  import eps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SITES    = 64;
  localparam int RATE_SLOTS = 4 * N_SITES;
  // Settle for SETTLE_CYCLES after the last result before touching
  // configuration or ending the run.
  localparam int SETTLE_CYCLES = 900;
  localparam longint CYCLE_LIMIT = 6_000_000;

  typedef struct {
    logic [1:0]  action;
    logic [5:0]  site;
    logic [31:0] wait_time;
    logic [47:0] elapsed_time;
  } event_result_t;

  // Mirrors the lattice rate table and the clock of the event engine, and
  // holds the results still owed by the block in request order.
  class event_scoreboard;
    logic [31:0] rates[RATE_SLOTS];
    logic [63:0] now_time;
    logic [31:0] kon, koff, kstep, kq;
    logic [23:0] qfac;
    event_result_t owed[$];
    int mismatches;

    function new();
      foreach (rates[i]) rates[i] = '0;
      now_time = '0;
      kon = 32'd65536; koff = 32'd65536; kstep = 32'd65536; kq = 32'd65536;
      qfac = 24'd65536;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_BIND:    kon = v;
        CFG_UNBIND:  koff = v;
        CFG_HOP:     kstep = v;
        CFG_RECOVER: kq = v;
        CFG_REBIND:  qfac = v[23:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rate_at(int idx);
      return (idx < RATE_SLOTS) ? rates[idx] : 32'd0;
    endfunction

    // Drop writes past the end of the table.
    function void put(int idx, logic [31:0] v);
      if (idx < RATE_SLOTS) rates[idx] = v;
    endfunction

    function logic [31:0] rebind_val();
      logic [63:0] p;
      p = ({40'd0, qfac} * {32'd0, kon}) >> 16;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function logic [31:0] hop_free(logic [31:0] x);
      return (x == koff) ? 32'd0 : kstep;
    endfunction

    function logic [31:0] hop_bound(logic [31:0] x);
      return (x == koff) ? kstep : 32'd0;
    endfunction

    // ln(2^32/d) in Q.32 via leading-one search and truncating squarings.
    function logic [63:0] ln_recip(logic [31:0] d);
      int e;
      logic [63:0] x, f, nl, hi, lo;
      e = 31;
      while (e > 0 && d[e] == 1'b0) e--;
      x = ({32'd0, d} << (31 - e)) & 64'hFFFF_FFFF;
      f = '0;
      for (int i = 0; i < 32; i++) begin
        x = (x * x) >> 31;
        f = f << 1;
        if (x >= 64'h1_0000_0000) begin
          f[0] = 1'b1;
          x = x >> 1;
        end
      end
      nl = (64'(32 - e) << 32) - f;
      hi = nl >> 16;
      lo = nl & 64'hFFFF;
      return (hi * {32'd0, LN2_Q32} + ((lo * {32'd0, LN2_Q32}) >> 16)) >> 16;
    endfunction

    function void note_request(logic op, logic [31:0] dw, logic [31:0] dp);
      event_result_t r;
      logic [63:0] total, acc, lo_part, x, thr, wt;
      int pick, act, s, n;
      n = N_SITES;
      if (op == OP_INIT) begin
        foreach (rates[i]) rates[i] = (i < n) ? kon : 32'd0;
        now_time = '0;
        r = '{2'd0, 6'd0, 32'd0, 48'd0};
        owed.push_back(r);
        return;
      end
      total = '0;
      foreach (rates[i]) total += {32'd0, rates[i]};
      // Threshold is the ceiling of total * dp / 2^32.
      lo_part = total * {48'd0, dp[15:0]};
      x = total * {48'd0, dp[31:16]} + (lo_part >> 16);
      thr = x >> 16;
      if (x[15:0] != 0 || lo_part[15:0] != 0) thr++;
      acc = '0;
      pick = 0;
      for (int j = 0; j < RATE_SLOTS; j++) begin
        acc += {32'd0, rates[j]};
        if (acc >= thr) begin
          pick = j;
          break;
        end
      end
      act = pick / n;
      s = pick % n;
      case (act)
        0: begin
          put(s, 0);
          put(n + s, koff);
          put(2 * n + s - 1, 0);
          put(2 * n + s, hop_free(rate_at(n + s + 1)));
          put(3 * n + s, 0);
        end
        1: begin
          put(s, rebind_val());
          put(n + s, 0);
          put(2 * n + s, 0);
          put(2 * n + s - 1, hop_bound(rate_at(n + s - 1)));
          put(3 * n + s, kq);
        end
        2: begin
          put(s, rebind_val());
          put(s + 1, 0);
          put(n + s, 0);
          put(n + s + 1, koff);
          put(2 * n + s - 1, hop_bound(rate_at(n + s - 1)));
          put(2 * n + s, 0);
          put(2 * n + s + 1, hop_free(rate_at(n + s + 2)));
          put(3 * n + s, kq);
          put(3 * n + s + 1, 0);
        end
        default: begin
          put(s, kon);
          put(3 * n + s, 0);
        end
      endcase
      put(0, 0); put(n, 0); put(2 * n, 0); put(3 * n, 0);
      put(n - 1, 0); put(2 * n - 1, koff); put(3 * n - 1, 0); put(4 * n - 1, 0);
      if (total == 0) begin
        wt = 64'hFFFF_FFFF;
      end else begin
        wt = ln_recip((dw == 0) ? 32'd1 : dw) / total;
        if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
      end
      now_time += wt;
      if (now_time > {16'd0, TIME_MAX}) now_time = {16'd0, TIME_MAX};
      r.action = act[1:0];
      r.site = s[5:0];
      r.wait_time = wt[31:0];
      r.elapsed_time = now_time[47:0];
      owed.push_back(r);
    endfunction

    function void check_result(event_result_t got);
      event_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: action %0d site %0d wait %h elapsed %h",
                   got.action, got.site, got.wait_time, got.elapsed_time);
        return;
      end
      want = owed.pop_front();
      if (got.action !== want.action || got.site !== want.site ||
          got.wait_time !== want.wait_time || got.elapsed_time !== want.elapsed_time) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want action %0d site %0d wait %h elapsed %h, got %0d %0d %h %h",
                   want.action, want.site, want.wait_time, want.elapsed_time,
                   got.action, got.site, got.wait_time, got.elapsed_time);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  eps_in_if  req_ch ();
  eps_out_if rsp_ch ();

  exclusion_process_event_step_core #(.SITES(N_SITES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  event_scoreboard sb = new();

  // Idle percentages of the request sender and the result receiver.
  int send_idle_pct;
  int recv_idle_pct;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[exclusion_process_event_step_core] ERROR");
      $finish;
    end
  end

  // Receiver: toggle ready on the falling edge, take results on the rising edge.
  always @(negedge clk) begin
    if (!rst) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    event_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.action = rsp_ch.action;
      got.site = rsp_ch.site;
      got.wait_time = rsp_ch.wait_time;
      got.elapsed_time = rsp_ch.elapsed_time;
      sb.check_result(got);
    end
  end

  // Present one request, holding valid until the block takes it, and note it
  // in the scoreboard at the accepting edge.
  task automatic send_request(logic op, logic [31:0] dw, logic [31:0] dp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op = op;
    req_ch.draw_wait = dw;
    req_ch.draw_pick = dp;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, dw, dp);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic [31:0] b, logic [31:0] u, logic [31:0] h,
                           logic [31:0] r, logic [31:0] q);
    write_reg(CFG_BIND, b);
    write_reg(CFG_UNBIND, u);
    write_reg(CFG_HOP, h);
    write_reg(CFG_RECOVER, r);
    write_reg(CFG_REBIND, q);
  endtask

  // Mostly events with random draws, an occasional re-init, and some
  // draws pinned at their extremes.
  task automatic random_requests(int count);
    logic [31:0] dw, dp;
    for (int i = 0; i < count; i++) begin
      dw = $urandom();
      dp = $urandom();
      case ($urandom_range(15))
        0: dw = 32'd0;
        1: dw = 32'hFFFF_FFFF;
        2: dp = 32'd0;
        3: dp = 32'hFFFF_FFFF;
        default: ;
      endcase
      send_request(($urandom_range(39) == 0) ? OP_INIT : OP_EVENT, dw, dp);
    end
  endtask

  initial begin
    cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_INIT;
    req_ch.draw_wait = '0;
    req_ch.draw_pick = '0;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 78;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset-value rates: all equal, so the koff-equality tests hit often.
    // The table is undefined until the first init, so lead with one.
    send_request(OP_INIT, 32'd0, 32'd0);
    send_request(OP_EVENT, 32'd0, 32'd0);            // zero draw_wait, zero pick
    send_request(OP_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_EVENT, 32'd1, 32'h8000_0000);
    send_request(OP_EVENT, 32'h8000_0000, 32'h0000_0001);
    send_request(OP_EVENT, 32'h0000_FFFF, 32'hFFFF_0000);
    for (int i = 0; i < 8; i++)
      send_request(OP_EVENT, $urandom(), $urandom());
    send_request(OP_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_request(OP_EVENT, $urandom(), $urandom());
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Extreme rates: rebinding saturates, stepping disabled, koff minimal.
    write_all(32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'h00FF_FFFF);
    send_request(OP_INIT, $urandom(), $urandom());
    random_requests(120);
    // Hold off until the block has caught up, then continue.
    drain();
    random_requests(130);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Swap the idle ratios; zero kon gives a zero-sum table right after init.
    send_idle_pct = 78;
    recv_idle_pct = 18;
    write_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_request(OP_INIT, 32'd0, 32'd0);
    send_request(OP_EVENT, $urandom(), $urandom());  // zero total: largest wait
    random_requests(250);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // No idling; kon equal to koff so hop rates track bound/free neighbors.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_data = $urandom();
    write_all(cfg_data, cfg_data, $urandom(), $urandom(), $urandom_range(24'hFF_FFFF));
    send_request(OP_INIT, $urandom(), $urandom());
    random_requests(500);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("[exclusion_process_event_step_core] OK");
    end else begin
      $display("[exclusion_process_event_step_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
